FILE: hdl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg: shared definitions for the palette rotate blitter
// Item codes, register map, orientation codes, default geometry and the
// command bundle that drives the palette memory.
// ----------------------------------------------------------------------------
package prb_pkg;

    // Default geometry of the display and of the palette.
    localparam int PORTRAIT_WIDTH_DEF  = 240;
    localparam int PORTRAIT_ROWS_DEF   = 180;
    localparam int TOP_OFFSET_ROWS_DEF = 24;
    localparam int LANDSCAPE_WIDTH_DEF = 320;
    localparam int LANDSCAPE_ROWS_DEF  = 240;
    localparam int PALETTE_DEPTH_DEF   = 256;

    // Field widths of the stream items.
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;
    localparam int CHAN_W  = 8;
    localparam int ADDR_W  = 20;
    localparam int COLOR_W = 16;
    localparam int PITCH_W = 12;
    localparam int STEP_W  = PITCH_W + 1;

    // Reset values of the pitch registers.
    localparam int X_PITCH_RST = 1;
    localparam int Y_PITCH_RST = 240;

    // Kind of an input beat.
    typedef enum logic [MODE_W-1:0] {
        MODE_PALETTE = 2'd0,
        MODE_PIXEL   = 2'd1,
        MODE_FRAME   = 2'd2
    } mode_t;

    // Display orientation; the unused code behaves as landscape left.
    typedef enum logic [1:0] {
        ORIENT_PORTRAIT = 2'd0,
        ORIENT_RIGHT    = 2'd1,
        ORIENT_LEFT     = 2'd2
    } orient_t;

    // Configuration register map, word index.
    typedef enum logic [1:0] {
        REG_ORIENTATION = 2'd0,
        REG_X_PITCH     = 2'd1,
        REG_Y_PITCH     = 2'd2
    } reg_index_t;

    // Palette access command for one cycle.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } pal_cmd_t;

endpackage

FILE: hdl/prb_palette.sv
// ----------------------------------------------------------------------------
// prb_palette: RGB565 palette memory
// Converts 24-bit colors to RGB565 on a write and returns the stored color
// from a register in the cycle after a read. Indices beyond the palette depth read as black.
// ----------------------------------------------------------------------------
module prb_palette #(
    parameter int PALETTE_DEPTH = prb_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                          clk,
    input  prb_pkg::pal_cmd_t             cmd,
    input  logic [prb_pkg::INDEX_W-1:0]   index,
    input  logic [prb_pkg::CHAN_W-1:0]    red,
    input  logic [prb_pkg::CHAN_W-1:0]    green,
    input  logic [prb_pkg::CHAN_W-1:0]    blue,
    output logic [prb_pkg::COLOR_W-1:0]   color
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [prb_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
    logic [prb_pkg::COLOR_W-1:0] rdata_reg;
    logic                        hit_reg;
    logic                        hit;
    logic [AW-1:0]               addr;
    logic [prb_pkg::COLOR_W-1:0] wdata;

    // Range check and address of the entry.
    assign hit   = {1'b0, index} < (prb_pkg::INDEX_W + 1)'(PALETTE_DEPTH);
    assign addr  = index[AW-1:0];

    // Keep the top bits of each channel: 5 red, 6 green, 5 blue.
    assign wdata = {red[7:3], green[7:2], blue[7:3]};

    // Write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
            hit_reg   <= hit;
        end
    end

    assign color = hit_reg ? rdata_reg : '0;

endmodule

FILE: hdl/palette_rotate_blit.sv
// ----------------------------------------------------------------------------
// palette_rotate_blit: palette lookup blitter with display rotation
// Stores RGB565 palette entries and streams out colored pixels with their
// display word offsets for portrait or either landscape orientation.
// ----------------------------------------------------------------------------
// Pipeline: a pixel beat passes the lookup stage, then the output register.
// Throughput: one beat per cycle while m_tready keeps the output moving; the
// address walk is one add per beat, so beats follow back to back.
// Reset: registers take their reset values, position goes to the portrait
// start; palette contents stay undefined until written.
module palette_rotate_blit #(
    parameter int PORTRAIT_WIDTH  = prb_pkg::PORTRAIT_WIDTH_DEF,
    parameter int PORTRAIT_ROWS   = prb_pkg::PORTRAIT_ROWS_DEF,
    parameter int TOP_OFFSET_ROWS = prb_pkg::TOP_OFFSET_ROWS_DEF,
    parameter int LANDSCAPE_WIDTH = prb_pkg::LANDSCAPE_WIDTH_DEF,
    parameter int LANDSCAPE_ROWS  = prb_pkg::LANDSCAPE_ROWS_DEF,
    parameter int PALETTE_DEPTH   = prb_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // word_address[19:0], color[35:20], zero pad[39:36]
    output logic        m_tlast,   // frame_last
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW      = prb_pkg::ADDR_W;
    localparam int SW      = prb_pkg::STEP_W;
    localparam int PW      = prb_pkg::PITCH_W;
    localparam int MAX_W   = (PORTRAIT_WIDTH > LANDSCAPE_WIDTH) ?
                             PORTRAIT_WIDTH : LANDSCAPE_WIDTH;
    localparam int MAX_R   = (PORTRAIT_ROWS > LANDSCAPE_ROWS) ?
                             PORTRAIT_ROWS : LANDSCAPE_ROWS;
    localparam int COL_W   = $clog2(MAX_W);
    localparam int ROW_W   = $clog2(MAX_R);
    localparam logic [COL_W-1:0] P_COL_LAST = COL_W'(PORTRAIT_WIDTH - 1);
    localparam logic [COL_W-1:0] L_COL_LAST = COL_W'(LANDSCAPE_WIDTH - 1);
    localparam logic [ROW_W-1:0] P_ROW_LAST = ROW_W'(PORTRAIT_ROWS - 1);
    localparam logic [ROW_W-1:0] L_ROW_LAST = ROW_W'(LANDSCAPE_ROWS - 1);
    localparam logic [AW-1:0]    RST_START  =
        AW'(prb_pkg::Y_PITCH_RST * TOP_OFFSET_ROWS);
    localparam logic [SW-1:0]    RST_STEP     = SW'(prb_pkg::X_PITCH_RST);
    localparam logic [SW-1:0]    RST_ROW_STEP = SW'(prb_pkg::Y_PITCH_RST);

    // Configuration registers.
    logic [1:0]    orientation_reg;
    logic [PW-1:0] x_pitch_reg;
    logic [PW-1:0] y_pitch_reg;

    // Geometry of the frame in progress and the walk position.
    logic             act_portrait_reg, act_portrait_next;
    logic [SW-1:0]    act_step_reg,     act_step_next;
    logic [SW-1:0]    act_row_step_reg, act_row_step_next;
    logic [AW-1:0]    row_start_reg,    row_start_next;
    logic [AW-1:0]    pixel_addr_reg,   pixel_addr_next;
    logic [COL_W-1:0] col_reg,          col_next;
    logic [ROW_W-1:0] row_reg,          row_next;

    // Geometry a new frame would take from the current registers.
    logic          new_portrait;
    logic [AW-1:0] new_start;
    logic [SW-1:0] new_step;
    logic [SW-1:0] new_row_step;

    // Pipeline: lookup stage and output register.
    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_last_reg;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_addr_reg;
    logic [prb_pkg::COLOR_W-1:0] out_color_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          accept;
    logic          pix_acc;
    logic          frame_acc;
    logic          last_col;
    logic          last_row;
    logic          cfg_wr;
    logic [AW-1:0] x_ext;
    logic [AW-1:0] y_ext;
    logic [SW-1:0] x_step;
    logic [SW-1:0] y_step;
    prb_pkg::mode_t    mode;
    prb_pkg::pal_cmd_t pal_cmd;
    logic [prb_pkg::COLOR_W-1:0] pal_color;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= prb_pkg::ORIENT_PORTRAIT;
            x_pitch_reg     <= PW'(prb_pkg::X_PITCH_RST);
            y_pitch_reg     <= PW'(prb_pkg::Y_PITCH_RST);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                prb_pkg::REG_ORIENTATION: orientation_reg <= pwdata[1:0];
                prb_pkg::REG_X_PITCH:     x_pitch_reg     <= pwdata[PW-1:0];
                prb_pkg::REG_Y_PITCH:     y_pitch_reg     <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            prb_pkg::REG_ORIENTATION: prdata = {30'b0, orientation_reg};
            prb_pkg::REG_X_PITCH:     prdata = {{(32-PW){1'b0}}, x_pitch_reg};
            prb_pkg::REG_Y_PITCH:     prdata = {{(32-PW){1'b0}}, y_pitch_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame geometry from the registers
    // ------------------------------------------------------------------
    assign x_ext  = {{(AW-PW){x_pitch_reg[PW-1]}}, x_pitch_reg};
    assign y_ext  = {{(AW-PW){y_pitch_reg[PW-1]}}, y_pitch_reg};
    assign x_step = {x_pitch_reg[PW-1], x_pitch_reg};
    assign y_step = {y_pitch_reg[PW-1], y_pitch_reg};

    always_comb
    begin
        case (orientation_reg)
            prb_pkg::ORIENT_PORTRAIT:
            begin
                new_portrait = 1'b1;
                new_start    = y_ext * AW'(TOP_OFFSET_ROWS);
                new_step     = x_step;
                new_row_step = y_step;
            end
            prb_pkg::ORIENT_RIGHT:
            begin
                new_portrait = 1'b0;
                new_start    = y_ext * AW'(LANDSCAPE_WIDTH);
                new_step     = SW'(0) - y_step;
                new_row_step = x_step;
            end
            default:
            begin
                new_portrait = 1'b0;
                new_start    = x_ext * AW'(LANDSCAPE_ROWS);
                new_step     = y_step;
                new_row_step = SW'(0) - x_step;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign mode      = prb_pkg::mode_t'(s_tuser);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign pix_acc   = accept && (mode == prb_pkg::MODE_PIXEL);
    assign frame_acc = accept && (mode == prb_pkg::MODE_FRAME);

    // ------------------------------------------------------------------
    // Address walk
    // ------------------------------------------------------------------
    assign last_col = col_reg == (act_portrait_reg ? P_COL_LAST : L_COL_LAST);
    assign last_row = row_reg == (act_portrait_reg ? P_ROW_LAST : L_ROW_LAST);

    always_comb
    begin
        act_portrait_next = act_portrait_reg;
        act_step_next     = act_step_reg;
        act_row_step_next = act_row_step_reg;
        row_start_next    = row_start_reg;
        pixel_addr_next   = pixel_addr_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        if (frame_acc || (pix_acc && last_col && last_row))
        begin
            // New frame with the current register values.
            act_portrait_next = new_portrait;
            act_step_next     = new_step;
            act_row_step_next = new_row_step;
            row_start_next    = new_start;
            pixel_addr_next   = new_start;
            col_next          = '0;
            row_next          = '0;
        end
        else if (pix_acc && !last_col)
        begin
            col_next        = col_reg + COL_W'(1);
            pixel_addr_next = pixel_addr_reg +
                              {{(AW-SW){act_step_reg[SW-1]}}, act_step_reg};
        end
        else if (pix_acc)
        begin
            // Next row.
            col_next        = '0;
            row_next        = row_reg + ROW_W'(1);
            row_start_next  = row_start_reg +
                              {{(AW-SW){act_row_step_reg[SW-1]}}, act_row_step_reg};
            pixel_addr_next = row_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_portrait_reg <= 1'b1;
            act_step_reg     <= RST_STEP;
            act_row_step_reg <= RST_ROW_STEP;
            row_start_reg    <= RST_START;
            pixel_addr_reg   <= RST_START;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            act_portrait_reg <= act_portrait_next;
            act_step_reg     <= act_step_next;
            act_row_step_reg <= act_row_step_next;
            row_start_reg    <= row_start_next;
            pixel_addr_reg   <= pixel_addr_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Palette memory
    // ------------------------------------------------------------------
    assign pal_cmd.wr_en = accept && (mode == prb_pkg::MODE_PALETTE);
    assign pal_cmd.rd_en = pix_acc;

    prb_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .cmd   (pal_cmd),
        .index (s_tdata[7:0]),
        .red   (s_tdata[15:8]),
        .green (s_tdata[23:16]),
        .blue  (s_tdata[31:24]),
        .color (pal_color)
    );

    // ------------------------------------------------------------------
    // Lookup stage and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (pix_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the lookup stage and of the output beat.
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_addr_reg <= pixel_addr_reg;
            s1_last_reg <= last_col && last_row;
        end
        if (out_free)
        begin
            out_addr_reg  <= s1_addr_reg;
            out_color_reg <= pal_color;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_color_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule
